/* src/psrs_pkg.sv */
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared types and constants for the pressure sensor read sequencer: action,
// error and destination codes, sensor register addresses, the phase encoding
// and the structs that pass between the sequencer modules.
// ----------------------------------------------------------------------------
package psrs_pkg;

  // Field widths.
  localparam int unsigned ActionW = 2;
  localparam int unsigned TickW   = 32;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned DestW   = 2;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned CfgIdxW = 2;

  // Action codes carried by an input transfer.
  localparam logic [ActionW-1:0] ACT_POLL = 2'd0;
  localparam logic [ActionW-1:0] ACT_CAL  = 2'd1;
  localparam logic [ActionW-1:0] ACT_MEAS = 2'd2;

  // Error codes reported with a result.
  localparam logic [ErrW-1:0] ERR_NONE = 2'd0;
  localparam logic [ErrW-1:0] ERR_BUSY = 2'd1;
  localparam logic [ErrW-1:0] ERR_LOCK = 2'd2;
  localparam logic [ErrW-1:0] ERR_ID   = 2'd3;

  // Read destinations.
  localparam logic [DestW-1:0] DEST_ID    = 2'd0;
  localparam logic [DestW-1:0] DEST_CAL   = 2'd1;
  localparam logic [DestW-1:0] DEST_TEMP  = 2'd2;
  localparam logic [DestW-1:0] DEST_PRESS = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TEMP_WAIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_WAIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_TMO   = 2'd2;

  // Configuration reset values.
  localparam logic [WaitW-1:0] TEMP_WAIT_RST  = 16'd5;
  localparam logic [WaitW-1:0] PRESS_WAIT_RST = 16'd30;
  localparam logic [WaitW-1:0] LOCK_TMO_RST   = 16'd1000;

  // Sensor register map and commands.
  localparam logic [ByteW-1:0] CHIP_ID     = 8'h55;
  localparam logic [ByteW-1:0] REG_ID      = 8'hd0;
  localparam logic [ByteW-1:0] REG_CAL     = 8'haa;
  localparam logic [ByteW-1:0] REG_CTRL    = 8'hf4;
  localparam logic [ByteW-1:0] REG_DATA    = 8'hf6;
  localparam logic [ByteW-1:0] CMD_TEMP    = 8'h2e;
  localparam logic [ByteW-1:0] CMD_PRESS   = 8'hf4;

  // Transaction lengths.
  localparam logic [CountW-1:0] LEN_ONE   = 5'd1;
  localparam logic [CountW-1:0] LEN_TWO   = 5'd2;
  localparam logic [CountW-1:0] LEN_THREE = 5'd3;
  localparam logic [CountW-1:0] LEN_CAL   = 5'd22;

  // Sequencer phase, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_ASK_ID     = 10'b00_0000_0010,
    PH_RCV_ID     = 10'b00_0000_0100,
    PH_ASK_CAL    = 10'b00_0000_1000,
    PH_TEMP_CONV  = 10'b00_0001_0000,
    PH_TEMP_READ  = 10'b00_0010_0000,
    PH_TEMP_DONE  = 10'b00_0100_0000,
    PH_PRESS_CONV = 10'b00_1000_0000,
    PH_PRESS_READ = 10'b01_0000_0000,
    PH_FINISH     = 10'b10_0000_0000
  } phase_t;

  // Wait and timeout settings.
  typedef struct packed {
    logic [WaitW-1:0] temp_wait;
    logic [WaitW-1:0] press_wait;
    logic [WaitW-1:0] lock_tmo;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               bus_idle;
    logic [TickW-1:0]   now_ticks;
    logic [ByteW-1:0]   id_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              issue;
    logic              bus_read;
    logic [CountW-1:0] byte_count;
    logic [ByteW-1:0]  reg_byte;
    logic [ByteW-1:0]  cmd_byte;
    logic [DestW-1:0]  dest;
    logic              ready_res;
    logic [ErrW-1:0]   error_code;
  } res_t;

endpackage

/* src/psrs_cfg.sv */
// ----------------------------------------------------------------------------
// psrs_cfg
// Configuration register file: wait times for the two conversions and the
// lock timeout, written through the configuration channel.
// ----------------------------------------------------------------------------
module psrs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [psrs_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [psrs_pkg::WaitW-1:0]    wr_data,
  output psrs_pkg::cfg_t                cfg
);

  psrs_pkg::cfg_t cfg_r;
  psrs_pkg::cfg_t cfg_nxt;

  // Decode the register index; writes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        psrs_pkg::CFG_TEMP_WAIT:  cfg_nxt.temp_wait  = wr_data;
        psrs_pkg::CFG_PRESS_WAIT: cfg_nxt.press_wait = wr_data;
        psrs_pkg::CFG_LOCK_TMO:   cfg_nxt.lock_tmo   = wr_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_wait  <= psrs_pkg::TEMP_WAIT_RST;
      cfg_r.press_wait <= psrs_pkg::PRESS_WAIT_RST;
      cfg_r.lock_tmo   <= psrs_pkg::LOCK_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/psrs_step.sv */
// ----------------------------------------------------------------------------
// psrs_step
// Single-pass sequencer logic: from the current phase, the job start time,
// the settings and one input item, works out the next phase and start time
// and the transaction to issue.
// ----------------------------------------------------------------------------
module psrs_step (
  input  psrs_pkg::phase_t              phase,
  input  logic [psrs_pkg::TickW-1:0]    start_time,
  input  psrs_pkg::cfg_t                cfg,
  input  psrs_pkg::item_t               item,
  output psrs_pkg::phase_t              phase_nxt,
  output logic [psrs_pkg::TickW-1:0]    start_time_nxt,
  output psrs_pkg::res_t                res
);

  logic [psrs_pkg::TickW-1:0] elapsed;
  logic                       is_start;
  logic                       lock_hit;
  logic                       temp_done;
  logic                       press_done;

  // Elapsed time wraps modulo 2^32; the thresholds are zero-extended.
  assign elapsed    = item.now_ticks - start_time;
  assign is_start   = (item.action == psrs_pkg::ACT_CAL) || (item.action == psrs_pkg::ACT_MEAS);
  assign lock_hit   = elapsed > {{(psrs_pkg::TickW-psrs_pkg::WaitW){1'b0}}, cfg.lock_tmo};
  assign temp_done  = elapsed > {{(psrs_pkg::TickW-psrs_pkg::WaitW){1'b0}}, cfg.temp_wait};
  assign press_done = elapsed > {{(psrs_pkg::TickW-psrs_pkg::WaitW){1'b0}}, cfg.press_wait};

  always_comb begin
    res            = '0;
    phase_nxt      = phase;
    start_time_nxt = start_time;

    if (is_start) begin
      // A start request while a job runs abandons it with a busy error.
      if (phase != psrs_pkg::PH_IDLE) begin
        phase_nxt      = psrs_pkg::PH_IDLE;
        res.ready_res  = 1'b1;
        res.error_code = psrs_pkg::ERR_BUSY;
      end else begin
        start_time_nxt = item.now_ticks;
        res.issue      = 1'b1;
        if (item.action == psrs_pkg::ACT_CAL) begin
          res.byte_count = psrs_pkg::LEN_ONE;
          res.reg_byte   = psrs_pkg::REG_ID;
          phase_nxt      = psrs_pkg::PH_ASK_ID;
        end else begin
          res.byte_count = psrs_pkg::LEN_TWO;
          res.reg_byte   = psrs_pkg::REG_CTRL;
          res.cmd_byte   = psrs_pkg::CMD_TEMP;
          phase_nxt      = psrs_pkg::PH_TEMP_CONV;
        end
      end
    end else if (phase == psrs_pkg::PH_IDLE) begin
      res.ready_res = 1'b1;
    end else if (lock_hit) begin
      phase_nxt      = psrs_pkg::PH_IDLE;
      res.ready_res  = 1'b1;
      res.error_code = psrs_pkg::ERR_LOCK;
    end else if (item.bus_idle) begin
      // Advance the transaction sequence once the bus has gone idle.
      case (phase)
        psrs_pkg::PH_ASK_ID: begin
          res.issue      = 1'b1;
          res.bus_read   = 1'b1;
          res.byte_count = psrs_pkg::LEN_ONE;
          res.dest       = psrs_pkg::DEST_ID;
          phase_nxt      = psrs_pkg::PH_RCV_ID;
        end
        psrs_pkg::PH_RCV_ID: begin
          if (item.id_byte != psrs_pkg::CHIP_ID) begin
            phase_nxt      = psrs_pkg::PH_IDLE;
            res.ready_res  = 1'b1;
            res.error_code = psrs_pkg::ERR_ID;
          end else begin
            res.issue      = 1'b1;
            res.byte_count = psrs_pkg::LEN_ONE;
            res.reg_byte   = psrs_pkg::REG_CAL;
            phase_nxt      = psrs_pkg::PH_ASK_CAL;
          end
        end
        psrs_pkg::PH_ASK_CAL: begin
          res.issue      = 1'b1;
          res.bus_read   = 1'b1;
          res.byte_count = psrs_pkg::LEN_CAL;
          res.dest       = psrs_pkg::DEST_CAL;
          phase_nxt      = psrs_pkg::PH_FINISH;
        end
        psrs_pkg::PH_TEMP_CONV: begin
          if (temp_done) begin
            res.issue      = 1'b1;
            res.byte_count = psrs_pkg::LEN_ONE;
            res.reg_byte   = psrs_pkg::REG_DATA;
            phase_nxt      = psrs_pkg::PH_TEMP_READ;
          end
        end
        psrs_pkg::PH_TEMP_READ: begin
          res.issue      = 1'b1;
          res.bus_read   = 1'b1;
          res.byte_count = psrs_pkg::LEN_TWO;
          res.dest       = psrs_pkg::DEST_TEMP;
          phase_nxt      = psrs_pkg::PH_TEMP_DONE;
        end
        psrs_pkg::PH_TEMP_DONE: begin
          // The pressure command restarts the job timer.
          res.issue      = 1'b1;
          res.byte_count = psrs_pkg::LEN_TWO;
          res.reg_byte   = psrs_pkg::REG_CTRL;
          res.cmd_byte   = psrs_pkg::CMD_PRESS;
          start_time_nxt = item.now_ticks;
          phase_nxt      = psrs_pkg::PH_PRESS_CONV;
        end
        psrs_pkg::PH_PRESS_CONV: begin
          if (press_done) begin
            res.issue      = 1'b1;
            res.byte_count = psrs_pkg::LEN_ONE;
            res.reg_byte   = psrs_pkg::REG_DATA;
            phase_nxt      = psrs_pkg::PH_PRESS_READ;
          end
        end
        psrs_pkg::PH_PRESS_READ: begin
          res.issue      = 1'b1;
          res.bus_read   = 1'b1;
          res.byte_count = psrs_pkg::LEN_THREE;
          res.dest       = psrs_pkg::DEST_PRESS;
          phase_nxt      = psrs_pkg::PH_FINISH;
        end
        default: begin
          // Job finished: report ready and return to idle.
          phase_nxt     = psrs_pkg::PH_IDLE;
          res.ready_res = 1'b1;
        end
      endcase
    end
  end

endmodule

/* src/pressure_sensor_read_sequencer.sv */
// ----------------------------------------------------------------------------
// pressure_sensor_read_sequencer
// Sequences the I2C transactions that read a barometric pressure sensor:
// a calibration job (chip ID check, calibration table read) and a
// measurement job (temperature and pressure conversions and reads).
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    action, bus_idle, now_ticks, id_byte
//   out_     output     out_valid/out_ready  issue, bus_read, byte_count, reg_byte,
//                                            cmd_byte, dest, ready_res, error_code
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item is held in the input register after its transfer, then the
// sequencer logic writes its result to the output register that drives out_.
// One item per cycle is sustained while out_ is not stalled; the phase and
// start time update as an item leaves the input register, so the next item
// sees them at once. A stalled output holds the input register; in_ready
// drops only then. Synchronous reset returns the phase to idle, clears the
// start time and restores the settings to their reset values.
// ----------------------------------------------------------------------------
module pressure_sensor_read_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psrs_pkg::ActionW-1:0]  in_action,
  input  logic                          in_bus_idle,
  input  logic [psrs_pkg::TickW-1:0]    in_now_ticks,
  input  logic [psrs_pkg::ByteW-1:0]    in_id_byte,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_issue,
  output logic                          out_bus_read,
  output logic [psrs_pkg::CountW-1:0]   out_byte_count,
  output logic [psrs_pkg::ByteW-1:0]    out_reg_byte,
  output logic [psrs_pkg::ByteW-1:0]    out_cmd_byte,
  output logic [psrs_pkg::DestW-1:0]    out_dest,
  output logic                          out_ready_res,
  output logic [psrs_pkg::ErrW-1:0]     out_error_code,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psrs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [psrs_pkg::WaitW-1:0]    cfg_data
);

  psrs_pkg::cfg_t             cfg;
  psrs_pkg::item_t            item_r;
  logic                       item_vld_r;
  psrs_pkg::res_t             res_r;
  psrs_pkg::res_t             res_nxt;
  logic                       out_vld_r;
  psrs_pkg::phase_t           phase_r;
  psrs_pkg::phase_t           phase_nxt;
  logic [psrs_pkg::TickW-1:0] start_time_r;
  logic [psrs_pkg::TickW-1:0] start_time_nxt;
  logic                       advance;

  // Settings are always writable.
  assign cfg_ready = 1'b1;

  psrs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on when the output register is free or draining.
  assign advance  = item_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~item_vld_r | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action    <= in_action;
      item_r.bus_idle  <= in_bus_idle;
      item_r.now_ticks <= in_now_ticks;
      item_r.id_byte   <= in_id_byte;
    end
  end

  psrs_step u_step (
    .phase          (phase_r),
    .start_time     (start_time_r),
    .cfg            (cfg),
    .item           (item_r),
    .phase_nxt      (phase_nxt),
    .start_time_nxt (start_time_nxt),
    .res            (res_nxt)
  );

  // Sequencer state updates once per item, as it leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= psrs_pkg::PH_IDLE;
      start_time_r <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_issue      = res_r.issue;
  assign out_bus_read   = res_r.bus_read;
  assign out_byte_count = res_r.byte_count;
  assign out_reg_byte   = res_r.reg_byte;
  assign out_cmd_byte   = res_r.cmd_byte;
  assign out_dest       = res_r.dest;
  assign out_ready_res  = res_r.ready_res;
  assign out_error_code = res_r.error_code;

endmodule

/* tb/tb_pressure_sensor_read_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_pressure_sensor_read_sequencer
// Self-checking testbench for the pressure sensor read sequencer. A short
// table of directed items covers reset, both jobs, the error paths and tick
// wrap. Random job sequences then run under several wait and timeout settings.
// Every result is checked field by field against the directed table or an in-bench
// model of the sequencer, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_read_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [psrs_pkg::ActionW-1:0] ACT_SPARE  = 2'd3;
  localparam logic [psrs_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned        STALL_LIMIT = 5000;
  localparam int unsigned        SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // One row of the directed table.
  typedef struct {
    psrs_pkg::item_t it;
    bit              typed;
    psrs_pkg::res_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [psrs_pkg::ActionW-1:0]  in_action = psrs_pkg::ACT_POLL;
  logic                          in_bus_idle = 1'b0;
  logic [psrs_pkg::TickW-1:0]    in_now_ticks = '0;
  logic [psrs_pkg::ByteW-1:0]    in_id_byte = '0;

  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_issue;
  logic                          out_bus_read;
  logic [psrs_pkg::CountW-1:0]   out_byte_count;
  logic [psrs_pkg::ByteW-1:0]    out_reg_byte;
  logic [psrs_pkg::ByteW-1:0]    out_cmd_byte;
  logic [psrs_pkg::DestW-1:0]    out_dest;
  logic                          out_ready_res;
  logic [psrs_pkg::ErrW-1:0]     out_error_code;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [psrs_pkg::CfgIdxW-1:0]  cfg_index = psrs_pkg::CFG_TEMP_WAIT;
  logic [psrs_pkg::WaitW-1:0]    cfg_data = '0;

  // Model state and settings.
  psrs_pkg::phase_t           seq_phase = psrs_pkg::PH_IDLE;
  logic [psrs_pkg::TickW-1:0] job_start = '0;
  logic [psrs_pkg::WaitW-1:0] wait_temp = psrs_pkg::TEMP_WAIT_RST;
  logic [psrs_pkg::WaitW-1:0] wait_press = psrs_pkg::PRESS_WAIT_RST;
  logic [psrs_pkg::WaitW-1:0] lock_limit = psrs_pkg::LOCK_TMO_RST;

  psrs_pkg::res_t             txn_due[$];
  dir_row_t                   dir_rows[$];
  int unsigned                fail_count = 0;
  int unsigned                burst_left = 0;
  int unsigned                quiet_cycles = 0;
  logic [psrs_pkg::TickW-1:0] tick_now = '0;
  rx_mode_t                   rx_mode = RX_OPEN;
  int unsigned                mode_left = 0;

  pressure_sensor_read_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_bus_idle    (in_bus_idle),
    .in_now_ticks   (in_now_ticks),
    .in_id_byte     (in_id_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_issue      (out_issue),
    .out_bus_read   (out_bus_read),
    .out_byte_count (out_byte_count),
    .out_reg_byte   (out_reg_byte),
    .out_cmd_byte   (out_cmd_byte),
    .out_dest       (out_dest),
    .out_ready_res  (out_ready_res),
    .out_error_code (out_error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // A 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic psrs_pkg::res_t make_res(input logic issue, input logic rd,
                                              input logic [psrs_pkg::CountW-1:0] cnt,
                                              input logic [psrs_pkg::ByteW-1:0] rg,
                                              input logic [psrs_pkg::ByteW-1:0] cmd,
                                              input logic [psrs_pkg::DestW-1:0] dst,
                                              input logic rdy,
                                              input logic [psrs_pkg::ErrW-1:0] err);
    psrs_pkg::res_t r;
    r.issue = issue;
    r.bus_read = rd;
    r.byte_count = cnt;
    r.reg_byte = rg;
    r.cmd_byte = cmd;
    r.dest = dst;
    r.ready_res = rdy;
    r.error_code = err;
    return r;
  endfunction

  function automatic psrs_pkg::item_t make_item(input logic [psrs_pkg::ActionW-1:0] act,
                                                input logic idle,
                                                input logic [psrs_pkg::TickW-1:0] now,
                                                input logic [psrs_pkg::ByteW-1:0] id);
    psrs_pkg::item_t it;
    it.action = act;
    it.bus_idle = idle;
    it.now_ticks = now;
    it.id_byte = id;
    return it;
  endfunction

  // Computes the transaction that one accepted item causes and advances the
  // job phase.
  function automatic psrs_pkg::res_t next_transaction(input psrs_pkg::item_t it);
    psrs_pkg::res_t             r;
    logic [psrs_pkg::TickW-1:0] elapsed;
    r = '0;
    // A start request either opens a job or, when one is running, aborts it.
    if (it.action == psrs_pkg::ACT_CAL || it.action == psrs_pkg::ACT_MEAS) begin
      if (seq_phase != psrs_pkg::PH_IDLE) begin
        seq_phase = psrs_pkg::PH_IDLE;
        return make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_BUSY);
      end
      job_start = it.now_ticks;
      if (it.action == psrs_pkg::ACT_CAL) begin
        seq_phase = psrs_pkg::PH_ASK_ID;
        return make_res(1'b1, 1'b0, psrs_pkg::LEN_ONE, psrs_pkg::REG_ID, '0, '0,
                        1'b0, psrs_pkg::ERR_NONE);
      end
      seq_phase = psrs_pkg::PH_TEMP_CONV;
      return make_res(1'b1, 1'b0, psrs_pkg::LEN_TWO, psrs_pkg::REG_CTRL,
                      psrs_pkg::CMD_TEMP, '0, 1'b0, psrs_pkg::ERR_NONE);
    end
    if (seq_phase == psrs_pkg::PH_IDLE) begin
      r.ready_res = 1'b1;
      return r;
    end
    // The lock timer is checked before the bus state.
    elapsed = it.now_ticks - job_start;
    if (elapsed > {16'd0, lock_limit}) begin
      seq_phase = psrs_pkg::PH_IDLE;
      return make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_LOCK);
    end
    if (!it.bus_idle) begin
      return r;
    end
    case (seq_phase)
      psrs_pkg::PH_ASK_ID: begin
        r = make_res(1'b1, 1'b1, psrs_pkg::LEN_ONE, '0, '0, psrs_pkg::DEST_ID,
                     1'b0, psrs_pkg::ERR_NONE);
        seq_phase = psrs_pkg::PH_RCV_ID;
      end
      psrs_pkg::PH_RCV_ID: begin
        if (it.id_byte != psrs_pkg::CHIP_ID) begin
          r = make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_ID);
          seq_phase = psrs_pkg::PH_IDLE;
        end else begin
          r = make_res(1'b1, 1'b0, psrs_pkg::LEN_ONE, psrs_pkg::REG_CAL, '0, '0,
                       1'b0, psrs_pkg::ERR_NONE);
          seq_phase = psrs_pkg::PH_ASK_CAL;
        end
      end
      psrs_pkg::PH_ASK_CAL: begin
        r = make_res(1'b1, 1'b1, psrs_pkg::LEN_CAL, '0, '0, psrs_pkg::DEST_CAL,
                     1'b0, psrs_pkg::ERR_NONE);
        seq_phase = psrs_pkg::PH_FINISH;
      end
      psrs_pkg::PH_TEMP_CONV: begin
        if (elapsed > {16'd0, wait_temp}) begin
          r = make_res(1'b1, 1'b0, psrs_pkg::LEN_ONE, psrs_pkg::REG_DATA, '0, '0,
                       1'b0, psrs_pkg::ERR_NONE);
          seq_phase = psrs_pkg::PH_TEMP_READ;
        end
      end
      psrs_pkg::PH_TEMP_READ: begin
        r = make_res(1'b1, 1'b1, psrs_pkg::LEN_TWO, '0, '0, psrs_pkg::DEST_TEMP,
                     1'b0, psrs_pkg::ERR_NONE);
        seq_phase = psrs_pkg::PH_TEMP_DONE;
      end
      psrs_pkg::PH_TEMP_DONE: begin
        // The pressure command restarts the lock timer.
        r = make_res(1'b1, 1'b0, psrs_pkg::LEN_TWO, psrs_pkg::REG_CTRL,
                     psrs_pkg::CMD_PRESS, '0, 1'b0, psrs_pkg::ERR_NONE);
        job_start = it.now_ticks;
        seq_phase = psrs_pkg::PH_PRESS_CONV;
      end
      psrs_pkg::PH_PRESS_CONV: begin
        if (elapsed > {16'd0, wait_press}) begin
          r = make_res(1'b1, 1'b0, psrs_pkg::LEN_ONE, psrs_pkg::REG_DATA, '0, '0,
                       1'b0, psrs_pkg::ERR_NONE);
          seq_phase = psrs_pkg::PH_PRESS_READ;
        end
      end
      psrs_pkg::PH_PRESS_READ: begin
        r = make_res(1'b1, 1'b1, psrs_pkg::LEN_THREE, '0, '0, psrs_pkg::DEST_PRESS,
                     1'b0, psrs_pkg::ERR_NONE);
        seq_phase = psrs_pkg::PH_FINISH;
      end
      default: begin
        r.ready_res = 1'b1;
        seq_phase = psrs_pkg::PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Presents one item in bursts with random gaps, then records what it causes.
  task automatic send_item(input psrs_pkg::item_t it, input bit typed,
                           input psrs_pkg::res_t want);
    int unsigned    gap;
    psrs_pkg::res_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= it.action;
    in_bus_idle <= it.bus_idle;
    in_now_ticks <= it.now_ticks;
    in_id_byte <= it.id_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_transaction(it);
    txn_due.push_back(typed ? want : predicted);
  endtask

  // Holds input until every expected result is back and the block is quiet.
  task automatic settle;
    in_valid <= 1'b0;
    while (txn_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration transfer; the caller lowers cfg_valid after the last.
  task automatic write_setting(input logic [psrs_pkg::CfgIdxW-1:0] idx,
                               input logic [psrs_pkg::WaitW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      psrs_pkg::CFG_TEMP_WAIT:  wait_temp = val;
      psrs_pkg::CFG_PRESS_WAIT: wait_press = val;
      psrs_pkg::CFG_LOCK_TMO:   lock_limit = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [psrs_pkg::WaitW-1:0] t_wait,
                                input logic [psrs_pkg::WaitW-1:0] p_wait,
                                input logic [psrs_pkg::WaitW-1:0] lock);
    write_setting(psrs_pkg::CFG_TEMP_WAIT, t_wait);
    write_setting(psrs_pkg::CFG_PRESS_WAIT, p_wait);
    write_setting(psrs_pkg::CFG_LOCK_TMO, lock);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed jobs with random timing, plus aborts, bus-busy polls,
  // bad chip IDs and large time jumps.
  task automatic run_random(input int unsigned count, input int unsigned step_max);
    psrs_pkg::item_t it;
    int unsigned     pick;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) begin
        tick_now = $urandom();
      end else if ($urandom_range(0, 3) != 0) begin
        tick_now = tick_now + $urandom_range(0, step_max);
      end
      pick = $urandom_range(0, 99);
      it = make_item(psrs_pkg::ACT_POLL, ($urandom_range(0, 4) != 0), tick_now,
                     8'($urandom_range(0, 255)));
      if (seq_phase == psrs_pkg::PH_IDLE) begin
        if (pick < 44) it.action = psrs_pkg::ACT_CAL;
        else if (pick < 88) it.action = psrs_pkg::ACT_MEAS;
        else if (pick >= 94) it.action = ACT_SPARE;
      end else begin
        if (pick < 3) begin
          it.action = ($urandom_range(0, 1) != 0) ? psrs_pkg::ACT_CAL : psrs_pkg::ACT_MEAS;
        end else if (pick < 6) begin
          it.action = ACT_SPARE;
        end
      end
      if (seq_phase == psrs_pkg::PH_RCV_ID && $urandom_range(0, 99) < 85) begin
        it.id_byte = psrs_pkg::CHIP_ID;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Receiver stalls on a pattern of its own: open, light and heavy stretches.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      default:  out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    psrs_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (txn_due.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        fail_count++;
      end else begin
        want = txn_due.pop_front();
        check_field("issue", 8'(want.issue), 8'(out_issue));
        check_field("bus_read", 8'(want.bus_read), 8'(out_bus_read));
        check_field("byte_count", 8'(want.byte_count), 8'(out_byte_count));
        check_field("reg_byte", want.reg_byte, out_reg_byte);
        check_field("cmd_byte", want.cmd_byte, out_cmd_byte);
        check_field("dest", 8'(want.dest), 8'(out_dest));
        check_field("ready_res", 8'(want.ready_res), 8'(out_ready_res));
        check_field("error_code", 8'(want.error_code), 8'(out_error_code));
      end
    end
  end

  // Ends the run when no channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_pressure_sensor_read_sequencer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed table: reset state, both jobs, conversion waits, aborts,
    // bad chip ID and a lock timeout across the tick wrap.
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd0, 8'h00), 1'b1,
                         make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_NONE)});
    dir_rows.push_back('{make_item(ACT_SPARE, 1'b1, 32'd1, 8'hff), 1'b1,
                         make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_NONE)});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_CAL, 1'b0, 32'd100, 8'h00), 1'b1,
                         make_res(1'b1, 1'b0, psrs_pkg::LEN_ONE, psrs_pkg::REG_ID,
                                  '0, '0, 1'b0, psrs_pkg::ERR_NONE)});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b0, 32'd101, 8'h00), 1'b1, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd102, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd103, psrs_pkg::CHIP_ID),
                         1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd104, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd105, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_CAL, 1'b1, 32'd200, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd201, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd202, 8'haa), 1'b1,
                         make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_ID)});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_MEAS, 1'b1, 32'd300, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd303, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd305, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd306, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd307, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd310, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd340, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd341, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd342, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'd343, 8'h00), 1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_MEAS, 1'b0, 32'hffff_fff0, 8'hff),
                         1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_CAL, 1'b1, 32'hffff_fff1, 8'h00), 1'b1,
                         make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_BUSY)});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_MEAS, 1'b1, 32'hffff_ff00, 8'h00),
                         1'b0, '0});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'h0000_02e9, 8'h00), 1'b1,
                         make_res(1'b0, 1'b0, '0, '0, '0, '0, 1'b1, psrs_pkg::ERR_LOCK)});
    dir_rows.push_back('{make_item(psrs_pkg::ACT_POLL, 1'b1, 32'hffff_ffff, 8'hff),
                         1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random traffic under the reset settings, then under new ones, each
    // applied while the block is idle.
    tick_now = $urandom();
    run_random(283, 6);

    settle();
    apply_settings(16'd0, 16'd0, 16'd0);
    run_random(283, 0);

    settle();
    apply_settings(16'hffff, 16'hffff, 16'hffff);
    run_random(283, 5000);

    settle();
    write_setting(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    apply_settings(16'd3, 16'd12, 16'd60);
    run_random(283, 3);

    settle();
    apply_settings(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(200, 65535)));
    run_random(283, 40);

    settle();
    apply_settings(16'd1, 16'd0, 16'hffff);
    run_random(283, 2);

    settle();
    if (fail_count == 0) begin
      $display("tb_pressure_sensor_read_sequencer: done, clean");
    end else begin
      $display("tb_pressure_sensor_read_sequencer: done, errors");
    end
    $finish;
  end

endmodule
